[sv/rms_pkg.sv]
`timescale 1ns / 1ps

package rms_pkg;

   localparam int PROB_FRAC = 16;
   localparam int PROB_W    = PROB_FRAC + 1;
   localparam int PROB_ONE  = 65536;
   localparam int STEP_W    = 5;
   localparam int MODE_W    = 2;
   localparam int ACTION_W  = 4;
   localparam int REGRET_W  = 32;
   localparam int DELTA_W   = 32;
   localparam int STRAT_W   = 48;
   localparam int PROD_W    = 2 * PROB_W;

   localparam logic [MODE_W-1:0] MODE_REGRET  = 2'd0;
   localparam logic [MODE_W-1:0] MODE_CURRENT = 2'd1;
   localparam logic [MODE_W-1:0] MODE_AVERAGE = 2'd2;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_REGRET,
      ST_SUM,
      ST_START,
      ST_DIV,
      ST_MUL,
      ST_ACC,
      ST_EMIT
   } rms_state_type;

endpackage

[sv/rms_divider.sv]
`timescale 1ns / 1ps

module rms_divider #(
   parameter int WIDTH = 49
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  logic [WIDTH-1:0]            dividend,
   input  logic [WIDTH-1:0]            divisor,
   output logic                        done,
   output logic [rms_pkg::PROB_W-1:0]  quotient
);

   logic                               busy_ff, busy_in;
   logic                               done_ff, done_in;
   logic [rms_pkg::STEP_W-1:0]         step_ff, step_in;
   logic [WIDTH:0]                     rem_ff, rem_in;
   logic [WIDTH-1:0]                   divisor_ff, divisor_in;
   logic [rms_pkg::PROB_W-1:0]         quo_ff, quo_in;
   logic [WIDTH:0]                     trial;
   logic [WIDTH:0]                     diff;
   logic                               fits;

   // dividend never exceeds divisor, so the quotient has PROB_W bits
   always_comb begin
      trial = (step_ff == '0) ? rem_ff : {rem_ff[WIDTH-1:0], 1'b0};
      diff  = trial - {1'b0, divisor_ff};
      fits  = trial >= {1'b0, divisor_ff};

      busy_in    = busy_ff;
      done_in    = 1'b0;
      step_in    = step_ff;
      rem_in     = rem_ff;
      divisor_in = divisor_ff;
      quo_in     = quo_ff;

      if (start) begin
         busy_in    = 1'b1;
         step_in    = '0;
         rem_in     = {1'b0, dividend};
         divisor_in = divisor;
         quo_in     = '0;
      end else if (busy_ff) begin
         rem_in  = fits ? diff : trial;
         quo_in  = {quo_ff[rms_pkg::PROB_W-2:0], fits};
         step_in = step_ff + 1'b1;
         if (step_ff == rms_pkg::STEP_W'(rms_pkg::PROB_FRAC)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         step_ff <= step_in;
      end
      rem_ff     <= rem_in;
      divisor_ff <= divisor_in;
      quo_ff     <= quo_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

[sv/regret_matching_strategy.sv]
`timescale 1ns / 1ps

// Regret-matching node for counterfactual regret minimisation. One transaction is handled at a
// time and req_stall stays high until it is finished. Mode 0 adds a saturating delta to one
// action's regret, keeps the block busy in ST_REGRET and returns nothing. Mode 1 returns the
// current strategy and adds reach times probability into the strategy totals; it first forms
// the total over all actions, then per action runs a start state, the shared 17-step serial
// divider, a multiply, an accumulate and an emit. Mode 2 returns the average strategy the same
// way with no multiply or accumulate. A zero total skips the divider and gives every action the
// uniform probability. A stalled result holds the block in its emit state. Results come in
// action order, with rsp_last on the final action. Regret and strategy totals clear at reset.
module regret_matching_strategy #(
   parameter int ACTION_COUNT = 2
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic [rms_pkg::MODE_W-1:0]          req_mode,
   input  logic [rms_pkg::ACTION_W-1:0]        req_action_index,
   input  logic signed [rms_pkg::DELTA_W-1:0]  req_regret_delta,
   input  logic [rms_pkg::PROB_W-1:0]          req_reach_weight,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [rms_pkg::ACTION_W-1:0]        rsp_out_action,
   output logic [rms_pkg::PROB_W-1:0]          rsp_probability,
   output logic                                rsp_last
);

   localparam int IDX_W   = $clog2(ACTION_COUNT);
   localparam int TOTAL_W = rms_pkg::STRAT_W + $clog2(ACTION_COUNT);
   localparam logic [rms_pkg::PROB_W-1:0] UNIFORM =
      rms_pkg::PROB_W'(rms_pkg::PROB_ONE / ACTION_COUNT);
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ACTION_COUNT - 1);

   rms_pkg::rms_state_type                  state_ff, state_in;
   logic [IDX_W-1:0]                        idx_ff, idx_in;
   logic [rms_pkg::MODE_W-1:0]              mode_ff, mode_in;
   logic signed [rms_pkg::DELTA_W-1:0]      delta_ff, delta_in;
   logic [rms_pkg::PROB_W-1:0]              reach_ff, reach_in;
   logic [TOTAL_W-1:0]                      total_ff, total_in;
   logic [rms_pkg::PROB_W-1:0]              prob_ff, prob_in;
   logic [rms_pkg::PROD_W-1:0]              prod_ff, prod_in;
   logic                                    rsp_valid_ff, rsp_valid_in;
   logic [rms_pkg::ACTION_W-1:0]            rsp_action_ff, rsp_action_in;
   logic [rms_pkg::PROB_W-1:0]              rsp_prob_ff, rsp_prob_in;
   logic                                    rsp_last_ff, rsp_last_in;

   logic signed [rms_pkg::REGRET_W-1:0]     regret_ff [ACTION_COUNT];
   logic [rms_pkg::STRAT_W-1:0]             strat_ff [ACTION_COUNT];
   logic signed [rms_pkg::REGRET_W-1:0]     regret_in;
   logic [rms_pkg::STRAT_W-1:0]             strat_in;
   logic                                    regret_we;
   logic                                    strat_we;

   logic signed [rms_pkg::REGRET_W-1:0]     regret_rd;
   logic [rms_pkg::STRAT_W-1:0]             strat_rd;
   logic [TOTAL_W-1:0]                      operand;
   logic signed [rms_pkg::REGRET_W:0]       regret_add;
   logic [rms_pkg::STRAT_W:0]               strat_sum;
   logic                                    out_free;
   logic                                    div_start;
   logic                                    div_done;
   logic [rms_pkg::PROB_W-1:0]              div_quotient;

   rms_divider #(
      .WIDTH (TOTAL_W)
   ) u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (operand),
      .divisor  (total_ff),
      .done     (div_done),
      .quotient (div_quotient)
   );

   always_comb begin
      regret_rd = regret_ff[idx_ff];
      strat_rd  = strat_ff[idx_ff];
      if (mode_ff == rms_pkg::MODE_CURRENT) begin
         operand = regret_rd[rms_pkg::REGRET_W-1] ? '0 :
                   TOTAL_W'(regret_rd[rms_pkg::REGRET_W-2:0]);
      end else begin
         operand = TOTAL_W'(strat_rd);
      end
      regret_add = {regret_rd[rms_pkg::REGRET_W-1], regret_rd} +
                   {delta_ff[rms_pkg::DELTA_W-1], delta_ff};
      strat_sum  = {1'b0, strat_rd} + (rms_pkg::STRAT_W + 1)'(prod_ff);
      out_free   = !rsp_valid_ff || !rsp_stall;
   end

   always_comb begin
      state_in      = state_ff;
      idx_in        = idx_ff;
      mode_in       = mode_ff;
      delta_in      = delta_ff;
      reach_in      = reach_ff;
      total_in      = total_ff;
      prob_in       = prob_ff;
      prod_in       = prod_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_action_in = rsp_action_ff;
      rsp_prob_in   = rsp_prob_ff;
      rsp_last_in   = rsp_last_ff;
      regret_in     = regret_add[rms_pkg::REGRET_W-1:0];
      strat_in      = strat_sum[rms_pkg::STRAT_W-1:0];
      regret_we     = 1'b0;
      strat_we      = 1'b0;
      div_start     = 1'b0;

      case (state_ff)
         rms_pkg::ST_IDLE: begin
            if (req_valid) begin
               mode_in  = req_mode;
               delta_in = req_regret_delta;
               reach_in = req_reach_weight;
               total_in = '0;
               idx_in   = '0;
               case (req_mode)
                  rms_pkg::MODE_REGRET: begin
                     if ({1'b0, req_action_index} <
                         (rms_pkg::ACTION_W + 1)'(ACTION_COUNT)) begin
                        idx_in   = req_action_index[IDX_W-1:0];
                        state_in = rms_pkg::ST_REGRET;
                     end
                  end
                  rms_pkg::MODE_CURRENT: state_in = rms_pkg::ST_SUM;
                  rms_pkg::MODE_AVERAGE: state_in = rms_pkg::ST_SUM;
                  default:               state_in = rms_pkg::ST_IDLE;
               endcase
            end
         end
         rms_pkg::ST_REGRET: begin
            regret_we = 1'b1;
            if (regret_add[rms_pkg::REGRET_W] != regret_add[rms_pkg::REGRET_W-1]) begin
               regret_in = regret_add[rms_pkg::REGRET_W] ?
                           {1'b1, {(rms_pkg::REGRET_W-1){1'b0}}} :
                           {1'b0, {(rms_pkg::REGRET_W-1){1'b1}}};
            end
            state_in = rms_pkg::ST_IDLE;
         end
         rms_pkg::ST_SUM: begin
            total_in = total_ff + operand;
            if (idx_ff == LAST_IDX) begin
               idx_in   = '0;
               state_in = rms_pkg::ST_START;
            end else begin
               idx_in = idx_ff + 1'b1;
            end
         end
         rms_pkg::ST_START: begin
            if (total_ff == '0) begin
               prob_in  = UNIFORM;
               state_in = (mode_ff == rms_pkg::MODE_CURRENT) ? rms_pkg::ST_MUL :
                                                               rms_pkg::ST_EMIT;
            end else begin
               div_start = 1'b1;
               state_in  = rms_pkg::ST_DIV;
            end
         end
         rms_pkg::ST_DIV: begin
            if (div_done) begin
               prob_in  = div_quotient;
               state_in = (mode_ff == rms_pkg::MODE_CURRENT) ? rms_pkg::ST_MUL :
                                                               rms_pkg::ST_EMIT;
            end
         end
         rms_pkg::ST_MUL: begin
            prod_in  = rms_pkg::PROD_W'(reach_ff) * rms_pkg::PROD_W'(prob_ff);
            state_in = rms_pkg::ST_ACC;
         end
         rms_pkg::ST_ACC: begin
            strat_we = 1'b1;
            if (strat_sum[rms_pkg::STRAT_W]) begin
               strat_in = '1;
            end
            state_in = rms_pkg::ST_EMIT;
         end
         rms_pkg::ST_EMIT: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_action_in = rms_pkg::ACTION_W'(idx_ff);
               rsp_prob_in   = prob_ff;
               rsp_last_in   = idx_ff == LAST_IDX;
               if (idx_ff == LAST_IDX) begin
                  state_in = rms_pkg::ST_IDLE;
               end else begin
                  idx_in   = idx_ff + 1'b1;
                  state_in = rms_pkg::ST_START;
               end
            end
         end
         default: state_in = rms_pkg::ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= rms_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
         idx_ff       <= '0;
         mode_ff      <= rms_pkg::MODE_REGRET;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         idx_ff       <= idx_in;
         mode_ff      <= mode_in;
      end
      delta_ff      <= delta_in;
      reach_ff      <= reach_in;
      total_ff      <= total_in;
      prob_ff       <= prob_in;
      prod_ff       <= prod_in;
      rsp_action_ff <= rsp_action_in;
      rsp_prob_ff   <= rsp_prob_in;
      rsp_last_ff   <= rsp_last_in;
   end

   // per-action totals
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < ACTION_COUNT; k++) begin
            regret_ff[k] <= '0;
            strat_ff[k]  <= '0;
         end
      end else begin
         if (regret_we) begin
            regret_ff[idx_ff] <= regret_in;
         end
         if (strat_we) begin
            strat_ff[idx_ff] <= strat_in;
         end
      end
   end

   assign req_stall       = state_ff != rms_pkg::ST_IDLE;
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_out_action  = rsp_action_ff;
   assign rsp_probability = rsp_prob_ff;
   assign rsp_last        = rsp_last_ff;

endmodule

[sim/tb_top.sv]
`timescale 1ns / 1ps

module tb_top;

   localparam int ACTION_COUNT = 2;
   localparam logic [rms_pkg::MODE_W-1:0] MODE_UNUSED = 2'd3;
   localparam int STUCK_LIMIT = 2000;
   localparam int DRAIN_CYCLES = 100;

   // predicts the probability stream and keeps the results still owed by the block
   class prob_scoreboard #(int NACT = 2);
      typedef struct {
         logic [rms_pkg::ACTION_W-1:0] action;
         logic [rms_pkg::PROB_W-1:0]   prob;
         logic                         last;
      } prob_result_type;

      localparam longint unsigned STRAT_MAX = 64'h0000_FFFF_FFFF_FFFF;
      localparam longint REGRET_MAX = 64'sd2147483647;
      localparam longint REGRET_MIN = -64'sd2147483648;

      longint          regret_acc[NACT];
      longint unsigned strat_acc[NACT];
      prob_result_type owed_probs[$];

      function new();
         for (int k = 0; k < NACT; k++) begin
            regret_acc[k] = 0;
            strat_acc[k] = 0;
         end
      endfunction

      function int pending();
         return owed_probs.size();
      endfunction

      function void owe_all(longint unsigned p[NACT]);
         prob_result_type r;
         for (int k = 0; k < NACT; k++) begin
            r.action = rms_pkg::ACTION_W'(k);
            r.prob = p[k][rms_pkg::PROB_W-1:0];
            r.last = (k == NACT - 1);
            owed_probs.push_back(r);
         end
      endfunction

      function void note_request(logic [rms_pkg::MODE_W-1:0] mode,
                                 logic [rms_pkg::ACTION_W-1:0] act,
                                 logic signed [rms_pkg::DELTA_W-1:0] delta,
                                 logic [rms_pkg::PROB_W-1:0] reach);
         longint          sum;
         longint unsigned clipped[NACT];
         longint unsigned p[NACT];
         longint unsigned total;
         longint unsigned acc;
         total = 0;
         case (mode)
            rms_pkg::MODE_REGRET: begin
               if (int'(act) < NACT) begin
                  sum = regret_acc[act] + longint'(delta);
                  if (sum > REGRET_MAX) sum = REGRET_MAX;
                  if (sum < REGRET_MIN) sum = REGRET_MIN;
                  regret_acc[act] = sum;
               end
            end
            rms_pkg::MODE_CURRENT: begin
               for (int k = 0; k < NACT; k++) begin
                  clipped[k] = (regret_acc[k] > 0) ? longint'(regret_acc[k]) : 0;
                  total += clipped[k];
               end
               for (int k = 0; k < NACT; k++) begin
                  if (total != 0) p[k] = (clipped[k] * 64'(rms_pkg::PROB_ONE)) / total;
                  else p[k] = 64'(rms_pkg::PROB_ONE / NACT);
                  acc = strat_acc[k] + 64'(reach) * p[k];
                  strat_acc[k] = (acc > STRAT_MAX) ? STRAT_MAX : acc;
               end
               owe_all(p);
            end
            rms_pkg::MODE_AVERAGE: begin
               for (int k = 0; k < NACT; k++) total += strat_acc[k];
               for (int k = 0; k < NACT; k++) begin
                  if (total != 0) p[k] = (strat_acc[k] * 64'(rms_pkg::PROB_ONE)) / total;
                  else p[k] = 64'(rms_pkg::PROB_ONE / NACT);
               end
               owe_all(p);
            end
            default: ;
         endcase
      endfunction

      function string check_result(logic [rms_pkg::ACTION_W-1:0] act,
                                   logic [rms_pkg::PROB_W-1:0] prob, logic last);
         prob_result_type e;
         if (owed_probs.size() == 0)
            return $sformatf("result with nothing owed: action %0d probability %0d last %0d",
                             act, prob, last);
         e = owed_probs.pop_front();
         if (act !== e.action || prob !== e.prob || last !== e.last)
            return $sformatf("got action %0d probability %0d last %0d, owed %0d %0d %0d",
                             act, prob, last, e.action, e.prob, e.last);
         return "";
      endfunction
   endclass

   logic                               clock;
   logic                               reset;
   logic                               req_valid;
   logic                               req_stall;
   logic [rms_pkg::MODE_W-1:0]         req_mode;
   logic [rms_pkg::ACTION_W-1:0]       req_action_index;
   logic signed [rms_pkg::DELTA_W-1:0] req_regret_delta;
   logic [rms_pkg::PROB_W-1:0]         req_reach_weight;
   logic                               rsp_valid;
   logic                               rsp_stall = 1'b0;
   logic [rms_pkg::ACTION_W-1:0]       rsp_out_action;
   logic [rms_pkg::PROB_W-1:0]         rsp_probability;
   logic                               rsp_last;

   prob_scoreboard #(ACTION_COUNT) strategy_sb;
   int  mismatches = 0;
   int  stuck_cycles = 0;
   int  send_idle_pct = 20;
   int  recv_idle_pct = 55;
   bit  timed_out = 1'b0;

   regret_matching_strategy #(
      .ACTION_COUNT(ACTION_COUNT)
   ) DUT (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_mode(req_mode),
      .req_action_index(req_action_index),
      .req_regret_delta(req_regret_delta),
      .req_reach_weight(req_reach_weight),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_out_action(rsp_out_action),
      .rsp_probability(rsp_probability),
      .rsp_last(rsp_last)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   task automatic report_mismatch(input string msg);
      $display("tb_top: mismatch at %0t: %s", $realtime, msg);
      mismatches++;
   endtask

   always @(negedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         rsp_stall <= ($urandom_range(0, 99) < recv_idle_pct);
      end
   end

   // both channels seen at the rising edge
   always @(posedge clock) begin
      string msg;
      bit    moved;
      moved = 1'b0;
      if (!reset) begin
         if (req_valid && !req_stall) begin
            strategy_sb.note_request(req_mode, req_action_index, req_regret_delta,
                                     req_reach_weight);
            moved = 1'b1;
         end
         if (rsp_valid && !rsp_stall) begin
            msg = strategy_sb.check_result(rsp_out_action, rsp_probability, rsp_last);
            if (msg != "") report_mismatch(msg);
            moved = 1'b1;
         end
      end
      stuck_cycles = moved ? 0 : stuck_cycles + 1;
   end

   task automatic send_request(input logic [rms_pkg::MODE_W-1:0] mode,
                               input logic [rms_pkg::ACTION_W-1:0] act,
                               input logic [rms_pkg::DELTA_W-1:0] delta,
                               input logic [rms_pkg::PROB_W-1:0] reach);
      @(negedge clock);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid = 1'b0;
         @(negedge clock);
      end
      req_valid = 1'b1;
      req_mode = mode;
      req_action_index = act;
      req_regret_delta = delta;
      req_reach_weight = reach;
      do @(posedge clock); while (req_stall);
   endtask

   function automatic logic [rms_pkg::DELTA_W-1:0] pick_delta();
      case ($urandom_range(0, 4))
         0: return $urandom;
         1: return rms_pkg::DELTA_W'($urandom_range(0, 262143)) - 32'd131072;
         2: return $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
         3: return rms_pkg::DELTA_W'($urandom_range(0, 1 << 24));
         default: return -rms_pkg::DELTA_W'($urandom_range(0, 1 << 24));
      endcase
   endfunction

   function automatic logic [rms_pkg::PROB_W-1:0] pick_reach();
      case ($urandom_range(0, 7))
         0: return '0;
         1: return rms_pkg::PROB_W'($urandom_range(65537, 131071));
         2: return rms_pkg::PROB_W'(rms_pkg::PROB_ONE);
         default: return rms_pkg::PROB_W'($urandom_range(0, 65536));
      endcase
   endfunction

   task automatic send_regret(input int act, input logic [rms_pkg::DELTA_W-1:0] delta);
      send_request(rms_pkg::MODE_REGRET, rms_pkg::ACTION_W'(act), delta,
                   rms_pkg::PROB_W'($urandom));
   endtask

   task automatic send_query(input logic [rms_pkg::MODE_W-1:0] mode,
                             input logic [rms_pkg::PROB_W-1:0] reach);
      send_request(mode, rms_pkg::ACTION_W'($urandom), $urandom, reach);
   endtask

   task automatic run_directed();
      send_query(rms_pkg::MODE_AVERAGE, '0);
      send_query(rms_pkg::MODE_CURRENT, rms_pkg::PROB_W'(rms_pkg::PROB_ONE));
      send_query(rms_pkg::MODE_AVERAGE, '1);
      send_regret(0, 32'h7FFF_FFFF);
      send_regret(0, 32'h7FFF_FFFF);
      send_query(rms_pkg::MODE_CURRENT, 17'h1FFFF);
      send_regret(1, 32'h8000_0000);
      send_regret(1, 32'h8000_0000);
      send_request(rms_pkg::MODE_REGRET, 4'hF, 32'h0000_1000, '0);
      send_request(rms_pkg::MODE_REGRET, rms_pkg::ACTION_W'(ACTION_COUNT % 16),
                   32'h7FFF_FFFF, '1);
      send_request(MODE_UNUSED, 4'h0, 32'h7FFF_FFFF, '1);
      send_query(rms_pkg::MODE_CURRENT, '0);
      send_query(rms_pkg::MODE_AVERAGE, '0);
      send_regret(0, 32'h8000_0000);
      send_query(rms_pkg::MODE_CURRENT, 17'd40000);
      send_regret(1, 32'h7FFF_FFFF);
      send_regret(1, 32'h7FFF_FFFF);
      send_query(rms_pkg::MODE_CURRENT, 17'd1);
      send_regret(0, 32'h0000_0001);
      send_regret(1, 32'hFFFF_FFFF);
      send_query(rms_pkg::MODE_CURRENT, 17'd65535);
      send_query(rms_pkg::MODE_AVERAGE, '0);
   endtask

   // mostly update-then-query episodes, with ignored transactions mixed in
   task automatic run_random(input int count);
      int done;
      int n;
      done = 0;
      while (done < count) begin
         if ($urandom_range(0, 99) < 10) begin
            if (ACTION_COUNT >= 16 || $urandom_range(0, 1))
               send_request(MODE_UNUSED, rms_pkg::ACTION_W'($urandom), $urandom,
                            rms_pkg::PROB_W'($urandom));
            else
               send_request(rms_pkg::MODE_REGRET,
                            rms_pkg::ACTION_W'($urandom_range(ACTION_COUNT, 15)),
                            $urandom, rms_pkg::PROB_W'($urandom));
         end else begin
            n = $urandom_range(0, 4);
            for (int i = 0; i < n; i++) send_regret($urandom_range(0, ACTION_COUNT - 1),
                                                    pick_delta());
            send_query(rms_pkg::MODE_CURRENT, pick_reach());
            done += n + 1;
            if ($urandom_range(0, 3) == 0) begin
               send_query(rms_pkg::MODE_AVERAGE, rms_pkg::PROB_W'($urandom));
               done++;
            end
         end
      end
   endtask

   task automatic run_all();
      send_idle_pct = 20;
      recv_idle_pct = 55;
      run_directed();
      run_random(100);
      send_idle_pct = 55;
      recv_idle_pct = 20;
      run_random(100);
      send_idle_pct = 0;
      recv_idle_pct = 0;
      run_random(100);
      @(negedge clock);
      req_valid = 1'b0;
      while (strategy_sb.pending() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      while (strategy_sb.pending() != 0) begin
         report_mismatch($sformatf("%0d results never arrived", strategy_sb.pending()));
         void'(strategy_sb.owed_probs.pop_front());
      end
   endtask

   task automatic watch_progress();
      while (stuck_cycles < STUCK_LIMIT) @(posedge clock);
      timed_out = 1'b1;
   endtask

   initial begin
      strategy_sb = new();
      reset = 1'b1;
      req_valid = 1'b0;
      req_mode = '0;
      req_action_index = '0;
      req_regret_delta = '0;
      req_reach_weight = '0;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      fork
         run_all();
         watch_progress();
      join_any
      if (timed_out) begin
         $display("tb_top: done, errors");
      end else if (mismatches == 0) begin
         $display("tb_top: done, clean");
      end else begin
         $display("tb_top: done, errors");
      end
      $finish;
   end

endmodule

[files.f]
sv/rms_pkg.sv
sv/rms_divider.sv
sv/regret_matching_strategy.sv
sim/tb_top.sv
